>>> rtl/bf16_add_via_fp32_truncate_unit_macros.svh
// assertion macros shared by the checker
`ifndef BF16_ADD_VIA_FP32_TRUNCATE_UNIT_MACROS_SVH
`define BF16_ADD_VIA_FP32_TRUNCATE_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// shared constants for the bfloat16 adder
// ----------------------------------------------------------------------------
`default_nettype none
package bfa_pkg;
    localparam int unsigned BfWidth = 16;
    localparam logic [15:0] BfDefaultNan = 16'hFFC0;
    typedef logic [BfWidth-1:0] bf16_t;
endpackage
`default_nettype wire

>>> rtl/bf16_add_via_fp32_truncate_unit.sv
// pipeline: input register, one pass of add logic, then result register,
// which acts as output stage; one word per cycle while the output is not
// stalled
// reset: flush_subnormals clears to 0, both valid flags clear
// ----------------------------------------------------------------------------
// bf16_add_via_fp32_truncate_unit
// streaming bfloat16 adder, fp32 round-to-nearest-even then truncate
// ----------------------------------------------------------------------------
`default_nettype none
module bf16_add_via_fp32_truncate_unit (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire        cfg_wdata,       // flush_subnormals
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [31:0] s_axis_tdata,    // [15:0] augend, [31:16] addend
    input  wire        s_axis_tlast,    // end_of_vector
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sum
    output logic       m_axis_tlast     // end_of_vector_out
);
    import bfa_pkg::*;

    logic  flush_reg;
    logic  in_vld_reg, out_vld_reg;
    bf16_t a_reg, b_reg, sum_reg, sum_next;
    logic  last_reg, olast_reg;
    logic  adv;

    // register config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flush_reg <= 1'b0;
        else if (cfg_we)
            flush_reg <= cfg_wdata;
    end

    // stage 2 moves when empty or being drained
    assign adv = !out_vld_reg || m_axis_tready;
    // stage 1 refills whenever it will pass its word on
    assign s_axis_tready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_vld_reg <= s_axis_tvalid;
            if (adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            a_reg    <= s_axis_tdata[15:0];
            b_reg    <= s_axis_tdata[31:16];
            last_reg <= s_axis_tlast;
        end
        if (adv && in_vld_reg)
        begin
            sum_reg   <= sum_next;
            olast_reg <= last_reg;
        end
    end

    bfa_core u_core (
        .a     (a_reg),
        .b     (b_reg),
        .flush (flush_reg),
        .y     (sum_next)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = sum_reg;
    assign m_axis_tlast  = olast_reg;
endmodule
`default_nettype wire

>>> rtl/bfa_core.sv
// ----------------------------------------------------------------------------
// bfa_core
// combinational bfloat16 add through fp32 rounding, truncated back to bf16
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_core (
    input  wire bfa_pkg::bf16_t a,
    input  wire bfa_pkg::bf16_t b,
    input  wire                 flush,
    output bfa_pkg::bf16_t      y
);
    import bfa_pkg::*;

    logic        a_nan, b_nan, a_inf, b_inf;
    bf16_t       af, bf;
    logic [7:0]  ea, eb, e_big, e_sml;
    logic [23:0] ma, mb;
    logic        big_a, s_big, s_sml;
    logic [26:0] m_big, m_sml, sh;
    logic [7:0]  d;
    logic [27:0] s;
    logic [4:0]  lz;
    logic [9:0]  e;
    logic [27:0] n;
    logic [24:0] r;
    logic        rnd;
    logic [9:0]  ef;
    logic [23:0] mf;
    logic [31:0] f;

    always_comb
    begin
        a_nan = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
        b_nan = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
        a_inf = a[14:0] == 15'h7F80;
        b_inf = b[14:0] == 15'h7F80;
        af = (flush && a[14:7] == 8'd0) ? {a[15], 15'd0} : a;
        bf = (flush && b[14:7] == 8'd0) ? {b[15], 15'd0} : b;
        ea = (af[14:7] == 8'd0) ? 8'd1 : af[14:7];
        eb = (bf[14:7] == 8'd0) ? 8'd1 : bf[14:7];
        ma = {af[14:7] != 8'd0, af[6:0], 16'd0};
        mb = {bf[14:7] != 8'd0, bf[6:0], 16'd0};
        big_a = (ea > eb) || (ea == eb && ma >= mb);
        s_big = big_a ? af[15] : bf[15];
        s_sml = big_a ? bf[15] : af[15];
        e_big = big_a ? ea : eb;
        e_sml = big_a ? eb : ea;
        m_big = {big_a ? ma : mb, 3'd0};
        m_sml = {big_a ? mb : ma, 3'd0};
        d = e_big - e_sml;
        if (d >= 8'd28)
            sh = {26'd0, m_sml != 27'd0};
        else
            sh = (m_sml >> d[4:0]) | {26'd0, (m_sml & ~(27'h7FFFFFF << d[4:0])) != 27'd0};
        s = (s_big == s_sml) ? {1'b0, m_big} + {1'b0, sh} : {1'b0, m_big} - {1'b0, sh};
        // leading zero count of the 27-bit magnitude
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
            if (s[i]) lz = 5'(26 - i);
        e = {2'b0, e_big};
        if (s[27])
        begin
            n = {1'b0, s[27:2], s[1] | s[0]};
            e = e + 10'd1;
        end
        else if ({5'd0, lz} < e - 10'd1)
        begin
            n = s << lz;
            e = e - {5'd0, lz};
        end
        else
        begin
            n = s << (e[4:0] - 5'd1);
            e = 10'd1;
        end
        rnd = n[2] && (n[1] || n[0] || n[3]);
        r = {1'b0, n[26:3]} + {24'd0, rnd};
        ef = e;
        mf = r[23:0];
        if (r[24])
        begin
            mf = r[24:1];
            ef = e + 10'd1;
        end
        if (ef >= 10'd255)
            f = {s_big, 8'hFF, 23'd0};
        else if (!mf[23])
            f = flush ? {s_big, 31'd0} : {s_big, 8'd0, mf[22:0]};
        else
            f = {s_big, ef[7:0], mf[22:0]};
        if (s == 28'd0)
            f = (af[14:0] == 15'd0 && bf[14:0] == 15'd0) ? {af[15] & bf[15], 31'd0} : 32'd0;

        if (a_nan)
            y = a | 16'h0040;
        else if (b_nan)
            y = b | 16'h0040;
        else if (a_inf && b_inf && (a[15] ^ b[15]))
            y = BfDefaultNan;
        else if (a_inf)
            y = a;
        else if (b_inf)
            y = b;
        else
            y = f[31:16];
    end
endmodule
`default_nettype wire

>>> rtl/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// port-level checks of the adder stream behavior
// ----------------------------------------------------------------------------
`default_nettype none
`include "bf16_add_via_fp32_truncate_unit_macros.svh"
module bfa_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    // stalled result keeps its value
    `BFA_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // with output drained the input side is open
    `BFA_ASSERT_IMP(a_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    // input closes only behind a stalled result
    `BFA_ASSERT_IMP(a_stall, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    // an accepted word passes through the input register to a valid result
    `BFA_ASSERT_NEXT(a_flow, clk, rst_n, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid)
endmodule
bind bf16_add_via_fp32_truncate_unit bfa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> tb/bf16_add_via_fp32_truncate_unit_tb.sv
// ----------------------------------------------------------------------------
// bf16_add_via_fp32_truncate_unit_tb
// streams bfloat16 operand pairs through the adder under random gaps and
// back-pressure, predicts each sum with an independent fp32 add model and
// checks every result word in order
// ----------------------------------------------------------------------------
`default_nettype none
module bf16_add_via_fp32_truncate_unit_tb;
    import bfa_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 8;

    // expected sum and marker for one word
    typedef struct packed {
        bf16_t sum;
        logic  eov;
    } sum_word_t;

    // predicts sums and checks result words in order
    class sum_scoreboard;
        sum_word_t pending[$];
        bit        flush;
        int        errors;

        function new();
            flush  = 1'b0;
            errors = 0;
        endfunction

        // fp32 add of two finite values, round to nearest even
        function logic [31:0] fp32_add(logic [31:0] x, logic [31:0] y);
            logic        sx, sy, big_s;
            logic [8:0]  ex, ey, e, d;
            logic [27:0] mx, my, big_m, small_m, s;
            logic [2:0]  grs;
            sx = x[31];
            sy = y[31];
            ex = {1'b0, x[30:23]};
            ey = {1'b0, y[30:23]};
            mx = {5'd0, x[22:0]};
            my = {5'd0, y[22:0]};
            if (ex == 0 && mx == 0 && ey == 0 && my == 0)
                return {sx & sy, 31'd0};
            if (ex != 0) mx[23] = 1'b1; else ex = 9'd1;
            if (ey != 0) my[23] = 1'b1; else ey = 9'd1;
            if (ex > ey || (ex == ey && mx >= my))
            begin
                big_s = sx; big_m = mx << 3; small_m = my << 3; e = ex; d = ex - ey;
            end
            else
            begin
                big_s = sy; big_m = my << 3; small_m = mx << 3; e = ey; d = ey - ex;
            end
            if (d >= 28)
                small_m = (small_m != 0) ? 28'd1 : 28'd0;
            else if (d > 0)
                small_m = (small_m >> d)
                        | {27'd0, (small_m & ((28'd1 << d) - 28'd1)) != 28'd0};
            s = (sx == sy) ? big_m + small_m : big_m - small_m;
            if (s == 0)
                return 32'd0;
            if (s[27])
            begin
                s = (s >> 1) | {27'd0, s[0]};
                e = e + 9'd1;
            end
            else
            begin
                while (!s[26] && e > 1)
                begin
                    s = s << 1;
                    e = e - 9'd1;
                end
            end
            grs = s[2:0];
            s = s >> 3;
            if (grs > 4 || (grs == 4 && s[0]))
                s = s + 28'd1;
            if (s[24])
            begin
                s = s >> 1;
                e = e + 9'd1;
            end
            if (e >= 255)
                return {big_s, 8'hFF, 23'd0};
            if (!s[23])
            begin
                // subnormal result, exponent field zero
                if (flush)
                    return {big_s, 31'd0};
                return {big_s, 8'd0, s[22:0]};
            end
            return {big_s, e[7:0], s[22:0]};
        endfunction

        function bf16_t predict_sum(bf16_t a, bf16_t b);
            logic        a_nan, b_nan, a_inf, b_inf;
            logic [31:0] r;
            a_nan = (a[14:7] == 8'hFF) && (a[6:0] != 0);
            b_nan = (b[14:7] == 8'hFF) && (b[6:0] != 0);
            a_inf = (a[14:0] == 15'h7F80);
            b_inf = (b[14:0] == 15'h7F80);
            if (a_nan) return a | 16'h0040;
            if (b_nan) return b | 16'h0040;
            if (a_inf && b_inf && (a[15] ^ b[15])) return BfDefaultNan;
            if (a_inf) return a;
            if (b_inf) return b;
            if (flush)
            begin
                if (a[14:7] == 0) a = {a[15], 15'd0};
                if (b[14:7] == 0) b = {b[15], 15'd0};
            end
            r = fp32_add({a, 16'd0}, {b, 16'd0});
            return r[31:16];
        endfunction

        function void note_operands(bf16_t a, bf16_t b, logic eov);
            sum_word_t w;
            w.sum = predict_sum(a, b);
            w.eov = eov;
            pending.push_back(w);
        endfunction

        function void check_result(bf16_t sum, logic eov);
            sum_word_t w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result sum %h last %b", $time, sum, eov);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (sum !== w.sum)
            begin
                $display("%0t: sum mismatch expected %h actual %h", $time, w.sum, sum);
                errors++;
            end
            if (eov !== w.eov)
            begin
                $display("%0t: last mismatch expected %b actual %b", $time, w.eov, eov);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;      // [15:0] augend, [31:16] addend
    logic        s_axis_tlast;      // end_of_vector
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;      // [15:0] sum
    logic        m_axis_tlast;      // end_of_vector_out

    sum_scoreboard sb;
    int  idle_cycles;
    bit  long_hold;     // receiver holds off for a long stretch when set
    bit  sink_random;   // receiver stalls at random when set

    bf16_add_via_fp32_truncate_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gap length: mostly zero or short, now and then long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one operand word and wait for it to be taken
    // valid stays high into the next word unless a gap or a drain follows
    task automatic send_word(bf16_t a, bf16_t b, logic eov, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= eov;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_operands(a, b, eov);
        @(negedge clk);
    endtask

    task automatic write_flush(bit value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.flush = value;
    endtask

    // wait until every expected word has come out, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // random operand biased toward interesting encodings
    function bf16_t pick_operand();
        bf16_t v;
        int    r;
        v = bf16_t'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8) v[14:7] = 8'hFF;                            // inf or nan
        else if (r < 16) v[14:7] = 8'h00;                      // zero or subnormal
        else if (r < 22) v[14:7] = 8'hFE;                      // near overflow
        else if (r < 28) v[14:7] = 8'($urandom_range(1, 3));   // near underflow
        else if (r < 32) v[14:0] = 15'h7F80;                   // infinity
        else if (r < 36) v[14:0] = 15'd0;                      // zero
        return v;
    endfunction

    // random pair: often close exponents so cancellation and rounding occur
    task automatic random_pair(output bf16_t a, output bf16_t b);
        int r;
        a = pick_operand();
        b = pick_operand();
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            b[14:7] = 8'(a[14:7] + $urandom_range(0, 2) - 1);
            b[15]   = ~a[15];
        end
        else if (r < 35)
            b = a ^ 16'h8000;                                  // exact cancellation
        else if (r < 45)
            b[14:7] = 8'(a[14:7] - $urandom_range(8, 30));     // far smaller addend
    endtask

    task automatic directed_words();
        bf16_t ops [0:19][0:1];
        int i;
        ops[0]  = '{16'h0000, 16'h0000};   // +0 + +0
        ops[1]  = '{16'h8000, 16'h8000};   // -0 + -0
        ops[2]  = '{16'h8000, 16'h0000};   // mixed zeros
        ops[3]  = '{16'h3F80, 16'hBF80};   // exact cancellation
        ops[4]  = '{16'h7F80, 16'hFF80};   // opposite infinities
        ops[5]  = '{16'h7F80, 16'h3F80};   // one infinity
        ops[6]  = '{16'h3F80, 16'hFF80};   // addend infinity
        ops[7]  = '{16'h7F81, 16'h7FC5};   // augend nan wins, quieted
        ops[8]  = '{16'h3F80, 16'hFFA3};   // addend nan quieted
        ops[9]  = '{16'h7F7F, 16'h7F7F};   // overflow
        ops[10] = '{16'hFF7F, 16'hFF7F};   // negative overflow
        ops[11] = '{16'h0001, 16'h0001};   // subnormals
        ops[12] = '{16'h007F, 16'h8001};   // subnormal mix
        ops[13] = '{16'h0080, 16'h8001};   // result goes subnormal
        ops[14] = '{16'h3F80, 16'h3380};   // tiny addend, rounding
        ops[15] = '{16'h3F81, 16'hBF80};   // cancellation to small normal
        ops[16] = '{16'hFFFF, 16'h0000};   // all ones
        ops[17] = '{16'h7FFF, 16'hFFFF};   // two nans
        ops[18] = '{16'h4B80, 16'h3F80};   // large plus one
        ops[19] = '{16'h8080, 16'h0081};   // smallest normals
        for (i = 0; i < 20; i++)
            send_word(ops[i][0], ops[i][1], i[0], 1'b0);
    endtask

    task automatic random_words(int count);
        bf16_t a, b;
        int    i;
        for (i = 0; i < count; i++)
        begin
            random_pair(a, b);
            send_word(a, b, ($urandom_range(0, 7) == 0), ($urandom_range(0, 3) != 0));
        end
    endtask

    // receiver: random stalls, or a long counted hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (long_hold)
            m_axis_tready <= 1'b0;
        else if (!sink_random)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    // hold-off process: waits for the request, then counts cycles
    initial
    begin
        long_hold = 1'b0;
        wait (sink_random);
        repeat (600) @(negedge clk);
        long_hold = 1'b1;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
    end

    // result checking at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WatchdogLimit);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        sb            = new();
        idle_cycles   = 0;
        sink_random   = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset value: no flush
        directed_words();
        drain();
        sink_random = 1'b1;
        random_words(700);
        drain();

        // flush mode on
        write_flush(1'b1);
        directed_words();
        random_words(700);
        drain();

        // and back off
        write_flush(1'b0);
        random_words(600);
        drain();

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_core.sv
rtl/bf16_add_via_fp32_truncate_unit.sv
rtl/bfa_checker.sv
tb/bf16_add_via_fp32_truncate_unit_tb.sv
